// File: rtl/core/tqm_pkg.sv
// ---------------------------------------------------------------------------
// Timer queue package
// Field widths, command and result codes shared by the timer queue.
// ---------------------------------------------------------------------------
package tqm_pkg;

  localparam int CMD_W    = 2;
  localparam int NOW_W    = 63;
  localparam int IVL_W    = 32;
  localparam int ID_W     = 32;
  localparam int DL_W     = 64;
  localparam int KIND_W   = 3;
  localparam int IN_TDATA_W = 128;

  // most expirations reported by one tick
  localparam int MAX_OUT  = 16;
  localparam int EMIT_W   = $clog2(MAX_OUT);

  // command codes (s_axis_tuser)
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // result kinds (m_axis_tuser)
  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              last;
  } res_t;

endpackage

// File: rtl/core/timer_queue_manager.sv
// ---------------------------------------------------------------------------
// Timer queue manager
// Bounded table of timers with add, remove and tick commands; a tick
// reports the due timers ordered by deadline, then id, then slot.
// ---------------------------------------------------------------------------
// Add goes from the add step to the put step; remove and tick scan the table,
// then decide and put. A tick runs one full table scan through the single
//   slot-memory read port per expiration, up to 16 beats a tick.
// Throughput: one command at a time; s_axis_tready is high only when idle.
// Reset (rst_ni low, async): all slots free, id counter zero, no beat held.
//   Slot contents are not cleared; they are read only behind a valid bit.
// ---------------------------------------------------------------------------
module timer_queue_manager #(
  parameter int MAX_TIMERS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command channel
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, low bit up: now_ms[62:0], interval_ms[94:63], repeat_mode[95],
  //   target_id[127:96]
  input  logic [tqm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [tqm_pkg::CMD_W-1:0]        s_axis_tuser,
  // result channel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: id[31:0]
  output logic [tqm_pkg::ID_W-1:0]         m_axis_tdata,
  // tuser: kind[2:0]
  output logic [tqm_pkg::KIND_W-1:0]       m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(MAX_TIMERS);
  localparam logic [tqm_pkg::EMIT_W-1:0] EMIT_LAST = tqm_pkg::EMIT_W'(tqm_pkg::MAX_OUT - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD    = 3'd1;  // allocate slot, build result
  localparam logic [2:0] ST_SCAN   = 3'd2;  // walk every slot through the read port
  localparam logic [2:0] ST_DECIDE = 3'd3;  // act on scan winner
  localparam logic [2:0] ST_PUT    = 3'd4;  // hand result to output register

  logic [2:0] state_q, state_d;

  // captured command
  logic [tqm_pkg::CMD_W-1:0] cmd_q;
  logic [tqm_pkg::NOW_W-1:0] now_q;
  logic [tqm_pkg::IVL_W-1:0] interval_q;
  logic                      repeat_q;
  logic [tqm_pkg::ID_W-1:0]  target_q;

  // slot table: valid bits in flops, payload in memories
  logic [MAX_TIMERS-1:0]     valid_q;
  logic [tqm_pkg::ID_W-1:0]  mem_id  [MAX_TIMERS];
  logic [tqm_pkg::DL_W-1:0]  mem_dl  [MAX_TIMERS];
  logic [tqm_pkg::IVL_W-1:0] mem_int [MAX_TIMERS];
  logic                      mem_rep [MAX_TIMERS];

  logic [tqm_pkg::ID_W-1:0]  ctr_q, ctr_inc, ctr_next;

  // scan read pipe
  logic [CNT_W-1:0]          scan_cnt_q;
  logic                      issue;
  logic [IDX_W-1:0]          rd_addr;
  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_idx_q;
  logic [tqm_pkg::ID_W-1:0]  rd_id_q;
  logic [tqm_pkg::DL_W-1:0]  rd_dl_q;
  logic [tqm_pkg::IVL_W-1:0] rd_int_q;
  logic                      rd_rep_q;

  // scan winner
  logic                      best_vld_q, more_q;
  logic [IDX_W-1:0]          best_idx_q;
  logic [tqm_pkg::ID_W-1:0]  best_id_q;
  logic [tqm_pkg::DL_W-1:0]  best_dl_q;
  logic [tqm_pkg::IVL_W-1:0] best_int_q;
  logic                      best_rep_q;
  logic                      found_q;
  logic [IDX_W-1:0]          found_idx_q;
  logic [tqm_pkg::EMIT_W-1:0] emit_cnt_q;

  // output register
  logic                      m_tvalid_q;
  tqm_pkg::res_t             res_q, res_d, out_q;

  logic acc, out_free, put_load, scan_start, scan_done;
  logic full;
  logic [IDX_W-1:0] free_idx;
  logic cand_due, cand_earlier, take_best, rm_match, take_found;
  logic tick_last;
  logic we_all, we_dl;
  logic [IDX_W-1:0] wr_addr;
  logic [tqm_pkg::IVL_W-1:0] add_b;
  logic [tqm_pkg::DL_W-1:0]  sum;
  logic [tqm_pkg::IVL_W-1:0] in_ivl;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;
  assign put_load      = (state_q == ST_PUT) && out_free;

  // id counter skips zero on wrap
  assign ctr_inc  = ctr_q + 1'b1;
  assign ctr_next = (ctr_inc == '0) ? tqm_pkg::ID_W'(1) : ctr_inc;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
        full     = 1'b0;
      end
    end
  end

  // shared deadline adder: now plus new interval on add, plus stored
  // interval when a repeating timer is rearmed
  assign add_b = (state_q == ST_ADD) ? interval_q : best_int_q;
  assign sum   = {1'b0, now_q} + {{(tqm_pkg::DL_W - tqm_pkg::IVL_W){1'b0}}, add_b};

  // scan issue and evaluation
  assign issue     = (state_q == ST_SCAN) && (scan_cnt_q < SCAN_END);
  assign rd_addr   = scan_cnt_q[IDX_W-1:0];
  assign scan_done = (state_q == ST_SCAN) && !issue && !rd_vld_q;

  assign cand_due     = valid_q[rd_idx_q] && (rd_dl_q <= {1'b0, now_q});
  assign cand_earlier = (rd_dl_q < best_dl_q) ||
                        ((rd_dl_q == best_dl_q) && (rd_id_q < best_id_q));
  // strict compare: an equal later slot loses, so ties go to the lower slot
  assign take_best    = (state_q == ST_SCAN) && rd_vld_q && (cmd_q == tqm_pkg::CMD_TICK) &&
                        cand_due && (!best_vld_q || cand_earlier);
  assign rm_match     = valid_q[rd_idx_q] && (rd_id_q == target_q);
  assign take_found   = (state_q == ST_SCAN) && rd_vld_q && (cmd_q == tqm_pkg::CMD_REMOVE) &&
                        rm_match && !found_q;

  // last expiration when no other due timer was seen or the beat budget ends
  assign tick_last = !more_q || (emit_cnt_q == EMIT_LAST);

  assign scan_start = (acc && ((s_axis_tuser == tqm_pkg::CMD_REMOVE) ||
                               (s_axis_tuser == tqm_pkg::CMD_TICK))) ||
                      (put_load && !res_q.last);

  assign we_all  = (state_q == ST_ADD) && !full;
  assign we_dl   = (state_q == ST_DECIDE) && (cmd_q == tqm_pkg::CMD_TICK) &&
                   best_vld_q && best_rep_q;
  assign wr_addr = (state_q == ST_ADD) ? free_idx : best_idx_q;

  assign in_ivl = s_axis_tdata[94:63];

  // result for the add and decide steps
  always_comb begin
    res_d = res_q;
    if (state_q == ST_ADD) begin
      if (full) begin
        res_d = '{kind: tqm_pkg::KIND_FULL, id: '0, last: 1'b1};
      end else begin
        res_d = '{kind: tqm_pkg::KIND_ADDED, id: ctr_next, last: 1'b1};
      end
    end else if (state_q == ST_DECIDE) begin
      if (cmd_q == tqm_pkg::CMD_REMOVE) begin
        if (found_q) begin
          res_d = '{kind: tqm_pkg::KIND_REMOVED, id: target_q, last: 1'b1};
        end else begin
          res_d = '{kind: tqm_pkg::KIND_NOT_FOUND, id: '0, last: 1'b1};
        end
      end else if (best_vld_q) begin
        res_d = '{kind: tqm_pkg::KIND_EXPIRED, id: best_id_q, last: tick_last};
      end else begin
        res_d = '{kind: tqm_pkg::KIND_NONE, id: '0, last: 1'b1};
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (s_axis_tuser)
            tqm_pkg::CMD_ADD:    state_d = ST_ADD;
            tqm_pkg::CMD_REMOVE: state_d = ST_SCAN;
            tqm_pkg::CMD_TICK:   state_d = ST_SCAN;
            default:             state_d = ST_IDLE;   // unknown command dropped
          endcase
        end
      end
      ST_ADD:    state_d = ST_PUT;
      ST_SCAN:   if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_PUT;
      ST_PUT: begin
        if (out_free) state_d = res_q.last ? ST_IDLE : ST_SCAN;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      ctr_q      <= '0;
      scan_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      more_q     <= 1'b0;
      found_q    <= 1'b0;
      emit_cnt_q <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (issue) scan_cnt_q <= scan_cnt_q + 1'b1;

      if (acc) emit_cnt_q <= '0;

      if (scan_start) begin
        scan_cnt_q <= '0;
        best_vld_q <= 1'b0;
        more_q     <= 1'b0;
        found_q    <= 1'b0;
      end else begin
        if (take_best) best_vld_q <= 1'b1;
        // a second due timer means the current pick is not the last
        if ((state_q == ST_SCAN) && rd_vld_q && (cmd_q == tqm_pkg::CMD_TICK) &&
            cand_due && best_vld_q) begin
          more_q <= 1'b1;
        end
        if (take_found) found_q <= 1'b1;
      end

      if (we_all) begin
        valid_q[free_idx] <= 1'b1;
        ctr_q             <= ctr_next;
      end

      if (state_q == ST_DECIDE) begin
        if (cmd_q == tqm_pkg::CMD_REMOVE) begin
          if (found_q) valid_q[found_idx_q] <= 1'b0;
        end else if (best_vld_q) begin
          if (!best_rep_q) valid_q[best_idx_q] <= 1'b0;
          emit_cnt_q <= emit_cnt_q + 1'b1;
        end
      end

      if (put_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // datapath registers and slot memories
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q      <= s_axis_tuser;
      now_q      <= s_axis_tdata[62:0];
      interval_q <= (in_ivl == '0) ? tqm_pkg::IVL_W'(1) : in_ivl;
      repeat_q   <= s_axis_tdata[95];
      target_q   <= s_axis_tdata[127:96];
    end

    if (we_all) begin
      mem_id[wr_addr]  <= ctr_next;
      mem_int[wr_addr] <= interval_q;
      mem_rep[wr_addr] <= repeat_q;
    end
    if (we_all || we_dl) mem_dl[wr_addr] <= sum;

    rd_idx_q <= rd_addr;
    rd_id_q  <= mem_id[rd_addr];
    rd_dl_q  <= mem_dl[rd_addr];
    rd_int_q <= mem_int[rd_addr];
    rd_rep_q <= mem_rep[rd_addr];

    if (take_best) begin
      best_idx_q <= rd_idx_q;
      best_id_q  <= rd_id_q;
      best_dl_q  <= rd_dl_q;
      best_int_q <= rd_int_q;
      best_rep_q <= rd_rep_q;
    end
    if (take_found) found_idx_q <= rd_idx_q;

    if ((state_q == ST_ADD) || (state_q == ST_DECIDE)) res_q <= res_d;
    if (put_load) out_q <= res_q;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = out_q.id;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  // assigned, removed and expired ids are never zero; other kinds carry zero
  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == tqm_pkg::KIND_ADDED) ||
                      (m_axis_tuser == tqm_pkg::KIND_REMOVED) ||
                      (m_axis_tuser == tqm_pkg::KIND_EXPIRED))
    |-> (m_axis_tdata != '0))
    else $error("reported timer id is zero");

  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == tqm_pkg::KIND_FULL) ||
                      (m_axis_tuser == tqm_pkg::KIND_NOT_FOUND) ||
                      (m_axis_tuser == tqm_pkg::KIND_NONE))
    |-> (m_axis_tdata == '0) && m_axis_tlast)
    else $error("status beat carries id or is not last");

  // returning to idle only after the final beat was loaded
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put_load && res_q.last |=> s_axis_tready && m_axis_tvalid && m_axis_tlast)
    else $error("command ended without a last beat");

  // no scan read in flight while a new command can be taken
  a_no_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !rd_vld_q)
    else $error("scan read pending in idle");

endmodule

// File: dv/tb_timer_queue_manager.sv
// ---------------------------------------------------------------------------
// Timer queue manager testbench
// Drives add, remove and tick commands into the command stream and checks
// every result beat against a local model of the timer table: slot choice,
// id allocation, deadline math and the deadline/id/slot firing order.
// Both stream sides idle in random bursts; one phase holds the result side
// off for a long stretch so the block backs up into its command input.
// ---------------------------------------------------------------------------
module tb_timer_queue_manager;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMERS = 16;
  // cmd 3 is not decoded by the block: no beat, no state change
  localparam logic [tqm_pkg::CMD_W-1:0] CMD_BOGUS = 2'd3;
  localparam int MAX_REPORTS = 10;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // tdata, low bit up: now_ms, interval_ms, repeat_mode, target_id
  logic [tqm_pkg::IN_TDATA_W-1:0] s_axis_tdata  = '0;
  // tuser: cmd
  logic [tqm_pkg::CMD_W-1:0]      s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // tdata: id
  logic [tqm_pkg::ID_W-1:0]       m_axis_tdata;
  // tuser: kind
  logic [tqm_pkg::KIND_W-1:0]     m_axis_tuser;
  logic                           m_axis_tlast;

  // timer table as the testbench sees it
  bit                        tbl_live     [TIMERS];
  logic [tqm_pkg::ID_W-1:0]  tbl_id       [TIMERS];
  logic [tqm_pkg::DL_W-1:0]  tbl_due_at   [TIMERS];
  logic [tqm_pkg::IVL_W-1:0] tbl_period   [TIMERS];
  bit                        tbl_periodic [TIMERS];
  logic [tqm_pkg::ID_W-1:0]  last_id = '0;

  tqm_pkg::res_t             pending_beats[$];
  int                        mismatches    = 0;
  bit                        calm          = 1'b0;
  int                        rx_hold_cycles = 0;
  logic [tqm_pkg::NOW_W-1:0] clock_ms      = '0;

  timer_queue_manager #(
    .MAX_TIMERS(TIMERS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  function automatic void expect_beat(input logic [tqm_pkg::KIND_W-1:0] kind,
                                      input logic [tqm_pkg::ID_W-1:0] id,
                                      input logic last);
    tqm_pkg::res_t b;
    b.kind = kind;
    b.id   = id;
    b.last = last;
    pending_beats.push_back(b);
  endfunction

  // firing order: deadline, then id, then slot index
  function automatic bit fires_first(input int a, input int b);
    if (tbl_due_at[a] != tbl_due_at[b]) return tbl_due_at[a] < tbl_due_at[b];
    if (tbl_id[a] != tbl_id[b]) return tbl_id[a] < tbl_id[b];
    return a < b;
  endfunction

  // Apply one accepted command to the table and queue the beats it causes.
  function automatic void timer_table_step(input logic [tqm_pkg::CMD_W-1:0] cmd,
                                           input logic [tqm_pkg::NOW_W-1:0] now,
                                           input logic [tqm_pkg::IVL_W-1:0] ivl,
                                           input logic rpt,
                                           input logic [tqm_pkg::ID_W-1:0] tgt);
    int                        slot;
    int                        n;
    int                        best;
    int                        tmp;
    int                        cnt;
    int                        due[TIMERS];
    logic [tqm_pkg::IVL_W-1:0] period;
    slot = -1;
    n    = 0;
    case (cmd)
      tqm_pkg::CMD_ADD: begin
        for (int i = TIMERS - 1; i >= 0; i--) begin
          if (!tbl_live[i]) slot = i;
        end
        if (slot < 0) begin
          // full: counter stays put
          expect_beat(tqm_pkg::KIND_FULL, '0, 1'b1);
        end else begin
          last_id = last_id + 1'b1;
          if (last_id == '0) last_id = tqm_pkg::ID_W'(1);
          period = (ivl == '0) ? tqm_pkg::IVL_W'(1) : ivl;
          tbl_live[slot]     = 1'b1;
          tbl_id[slot]       = last_id;
          tbl_period[slot]   = period;
          tbl_periodic[slot] = rpt;
          tbl_due_at[slot]   = {1'b0, now} + tqm_pkg::DL_W'(period);
          expect_beat(tqm_pkg::KIND_ADDED, last_id, 1'b1);
        end
      end
      tqm_pkg::CMD_REMOVE: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (slot < 0 && tbl_live[i] && tbl_id[i] == tgt) slot = i;
        end
        if (slot < 0) begin
          expect_beat(tqm_pkg::KIND_NOT_FOUND, '0, 1'b1);
        end else begin
          tbl_live[slot] = 1'b0;
          expect_beat(tqm_pkg::KIND_REMOVED, tgt, 1'b1);
        end
      end
      tqm_pkg::CMD_TICK: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (tbl_live[i] && tbl_due_at[i] <= {1'b0, now}) begin
            due[n] = i;
            n++;
          end
        end
        if (n == 0) begin
          expect_beat(tqm_pkg::KIND_NONE, '0, 1'b1);
        end else begin
          for (int j = 0; j < n; j++) begin
            best = j;
            for (int k = j + 1; k < n; k++) begin
              if (fires_first(due[k], due[best])) best = k;
            end
            tmp       = due[j];
            due[j]    = due[best];
            due[best] = tmp;
          end
          cnt = (n < tqm_pkg::MAX_OUT) ? n : tqm_pkg::MAX_OUT;
          for (int j = 0; j < cnt; j++) begin
            expect_beat(tqm_pkg::KIND_EXPIRED, tbl_id[due[j]], j == cnt - 1);
            if (tbl_periodic[due[j]]) begin
              tbl_due_at[due[j]] = {1'b0, now} + tqm_pkg::DL_W'(tbl_period[due[j]]);
            end else begin
              tbl_live[due[j]] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one command beat; valid stays high after acceptance so a
  // back-to-back beat needs no second assignment in the same step.
  task automatic issue(input logic [tqm_pkg::CMD_W-1:0] cmd,
                       input logic [tqm_pkg::NOW_W-1:0] now,
                       input logic [tqm_pkg::IVL_W-1:0] ivl, input logic rpt,
                       input logic [tqm_pkg::ID_W-1:0] tgt);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {tgt, rpt, ivl, now};
    do @(posedge clk_i); while (!s_axis_tready);
    timer_table_step(cmd, now, ivl, rpt, tgt);
  endtask

  // Result side ready: random bursts, a counted long hold on request,
  // steady high once calm.
  initial begin : result_ready_gen
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    tqm_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected beat kind %0d id %0d last %0b",
                                m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata !== want.id ||
            m_axis_tlast !== want.last) begin
          note_mismatch($sformatf("exp kind %0d id %0d last %0b, got kind %0d id %0d last %0b",
                                  want.kind, want.id, want.last,
                                  m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end
      end
    end
  end

  // empty table, not-found removes, bogus cmd, zero and max interval, max now
  task automatic test_edge_cases();
    issue(tqm_pkg::CMD_TICK, '0, $urandom, 1'b1, $urandom);
    issue(tqm_pkg::CMD_REMOVE, tqm_pkg::NOW_W'({$urandom, $urandom}), $urandom, 1'b0, '0);
    issue(CMD_BOGUS, tqm_pkg::NOW_W'({$urandom, $urandom}), $urandom, 1'b1, $urandom);
    issue(tqm_pkg::CMD_ADD, '0, '0, 1'b0, $urandom);         // interval raised to 1
    issue(tqm_pkg::CMD_ADD, '1, '1, 1'b1, $urandom);         // largest deadline
    issue(tqm_pkg::CMD_TICK, '0, $urandom, 1'b0, $urandom);  // live but not yet due
    issue(tqm_pkg::CMD_TICK, 63'd1, $urandom, 1'b1, $urandom);
    issue(tqm_pkg::CMD_REMOVE, '0, '0, 1'b0, '1);
    issue(tqm_pkg::CMD_REMOVE, '0, '1, 1'b1, 32'd2);
  endtask

  // fill every slot, overflow once, then fire all at one tick
  task automatic test_full_table();
    for (int k = 0; k < TIMERS; k++) begin
      // four deadline groups so ordering needs both keys
      issue(tqm_pkg::CMD_ADD, 63'd100, tqm_pkg::IVL_W'(4 - k % 4), k[0], $urandom);
    end
    issue(tqm_pkg::CMD_ADD, 63'd100, 32'd1, 1'b0, $urandom);
    issue(tqm_pkg::CMD_TICK, 63'd200, $urandom, 1'b0, $urandom);
    clock_ms = 63'd200;
  endtask

  task automatic random_command();
    int                        pick;
    int                        live[$];
    logic [tqm_pkg::CMD_W-1:0] cmd;
    logic [tqm_pkg::NOW_W-1:0] now;
    logic [tqm_pkg::IVL_W-1:0] ivl;
    logic [tqm_pkg::ID_W-1:0]  tgt;
    logic                      rpt;
    clock_ms = clock_ms + tqm_pkg::NOW_W'($urandom_range(0, 12));
    now  = ($urandom_range(0, 99) < 6) ? tqm_pkg::NOW_W'({$urandom, $urandom}) : clock_ms;
    ivl  = $urandom;
    tgt  = $urandom;
    rpt  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      cmd  = tqm_pkg::CMD_ADD;
      pick = $urandom_range(0, 9);
      if (pick == 0) ivl = '0;
      else if (pick != 1) ivl = tqm_pkg::IVL_W'($urandom_range(1, 40));
    end else if (pick < 60) begin
      cmd = tqm_pkg::CMD_REMOVE;
      for (int i = 0; i < TIMERS; i++) begin
        if (tbl_live[i]) live.push_back(i);
      end
      if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
        tgt = tbl_id[live[$urandom_range(0, live.size() - 1)]];
      end
    end else if (pick < 96) begin
      cmd = tqm_pkg::CMD_TICK;
    end else begin
      cmd = CMD_BOGUS;
    end
    issue(cmd, now, ivl, rpt, tgt);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) random_command();
  endtask

  // long result-side hold while commands keep coming
  task automatic test_backpressure();
    rx_hold_cycles = 400;
    repeat (12) random_command();
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    repeat (40) random_command();
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    test_full_table();
    test_random_traffic(100);
    test_backpressure();
    test_steady_stream();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    // drain window: longer than a full remove scan
    repeat (4 * TIMERS + 16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
